/* rtl/cse_pkg.sv */
package cse_pkg;

    // Width of the key field on both streams.
    localparam int KEY_W      = 8;
    // Number of low key bits that select a histogram bin.
    localparam int VALUE_BITS = 8;
    // Largest number of keys counted in one batch.
    localparam int MAX_ITEMS  = 64;

    localparam int NUM_BINS   = 1 << VALUE_BITS;
    localparam int BIN_W      = VALUE_BITS;
    localparam int CNT_W      = 7;
    localparam int LOAD_W     = $clog2(MAX_ITEMS + 1);

endpackage

/* rtl/counting_sort_engine_unit.sv */
// Counting sort over batches of unsigned keys. Keys come in one per transfer on the
// s_axis side and are counted in a 256-bin histogram memory with one read and one
// write port; each counted key takes a read of the bin, then a write of the incremented
// count, so s_axis_tready drops for one cycle after every counted key that does not
// close the batch. Keys past the 64th of a batch are dropped without a stall and set
// the overflow flag that travels on m_axis_tuser with every result of that batch. The
// transfer with s_axis_tlast closes the batch; the block then walks the bins from zero
// upward, reading and then checking each bin visited, and sends each key once per
// count in ascending order, one result per cycle within a bin while m_axis_tready is
// high, with m_axis_tlast on the final one. Bins are cleared as they are read. No input
// is taken during emission. After reset the block clears every bin before it is ready.
module counting_sort_engine_unit import cse_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [KEY_W-1:0] s_axis_tdata,   // [7:0] key
    input  logic             s_axis_tlast,   // batch_end
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [KEY_W-1:0] m_axis_tdata,   // [7:0] sorted_key
    output logic             m_axis_tlast,   // run_end
    output logic             m_axis_tuser    // [0] overflowed
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INC,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_EMIT
    } t_state;

    t_state             r_state,  n_state;
    logic [BIN_W-1:0]   r_bin,    n_bin;
    logic [BIN_W-1:0]   r_key,    n_key;
    logic               r_last,   n_last;
    logic [LOAD_W-1:0]  r_loaded, n_loaded;
    logic               r_drop,   n_drop;
    logic [CNT_W-1:0]   r_cnt,    n_cnt;

    logic [CNT_W-1:0]   r_mem [NUM_BINS];
    logic [CNT_W-1:0]   r_rdata;

    logic               w_we;
    logic [BIN_W-1:0]   w_waddr;
    logic [CNT_W-1:0]   w_wdata;
    logic [BIN_W-1:0]   w_raddr;
    logic               w_in_xfer;
    logic               w_out_xfer;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_EMIT);
    assign m_axis_tdata  = KEY_W'(r_bin);
    assign m_axis_tlast  = (r_loaded == LOAD_W'(1));
    assign m_axis_tuser  = r_drop;

    assign w_in_xfer  = s_axis_tvalid && s_axis_tready;
    assign w_out_xfer = m_axis_tvalid && m_axis_tready;

    // One read and one write per cycle: reads follow the state, writes clear or increment.
    always_comb begin
        w_raddr = (r_state == ST_IDLE) ? s_axis_tdata[BIN_W-1:0] : r_bin;
        w_we    = 1'b0;
        w_waddr = r_bin;
        w_wdata = '0;
        case (r_state)
            ST_CLEAR: begin
                w_we = 1'b1;
            end
            ST_INC: begin
                w_we    = 1'b1;
                w_waddr = r_key;
                w_wdata = r_rdata + CNT_W'(1);
            end
            ST_SCAN_CHK: begin
                w_we = 1'b1;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_comb begin
        n_state  = r_state;
        n_bin    = r_bin;
        n_key    = r_key;
        n_last   = r_last;
        n_loaded = r_loaded;
        n_drop   = r_drop;
        n_cnt    = r_cnt;
        case (r_state)
            ST_CLEAR: begin
                n_bin = r_bin + BIN_W'(1);
                if (&r_bin) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_key  = s_axis_tdata[BIN_W-1:0];
                    n_last = s_axis_tlast;
                    if (r_loaded < LOAD_W'(MAX_ITEMS)) begin
                        n_loaded = r_loaded + LOAD_W'(1);
                        n_state  = ST_INC;
                    end else begin
                        n_drop = 1'b1;
                        if (s_axis_tlast) begin
                            n_bin   = '0;
                            n_state = ST_SCAN_RD;
                        end
                    end
                end
            end
            ST_INC: begin
                if (r_last) begin
                    n_bin   = '0;
                    n_state = ST_SCAN_RD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN_RD: begin
                n_state = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                if (r_rdata == '0) begin
                    n_bin   = r_bin + BIN_W'(1);
                    n_state = ST_SCAN_RD;
                end else begin
                    n_cnt   = r_rdata;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_xfer) begin
                    n_loaded = r_loaded - LOAD_W'(1);
                    n_cnt    = r_cnt - CNT_W'(1);
                    if (r_loaded == LOAD_W'(1)) begin
                        // Every loaded key has gone out, so the bins above are empty.
                        n_drop  = 1'b0;
                        n_state = ST_IDLE;
                    end else if (r_cnt == CNT_W'(1)) begin
                        n_bin   = r_bin + BIN_W'(1);
                        n_state = ST_SCAN_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_bin    <= '0;
            r_loaded <= '0;
            r_drop   <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_bin    <= n_bin;
            r_loaded <= n_loaded;
            r_drop   <= n_drop;
            r_last   <= n_last;
        end
        r_key <= n_key;
        r_cnt <= n_cnt;
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input accepted while emitting");

    a_emit_has_keys: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_loaded != '0) && (r_cnt != '0))
        else $error("result shown with nothing left to send");

    a_loaded_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loaded <= LOAD_W'(MAX_ITEMS))
        else $error("batch count beyond limit");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=>
            (r_state == ST_IDLE) && (r_loaded == '0) && !r_drop)
        else $error("batch state not cleared after final result");

    a_last_in_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (r_cnt == CNT_W'(1)))
        else $error("final result while bin still holds keys");

endmodule

/* bench/counting_sort_engine_unit_tb.sv */
`timescale 1ns / 1ps

module counting_sort_engine_unit_tb;
    import cse_pkg::*;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             batch_end;
    } t_key_item;

    typedef struct packed {
        logic [KEY_W-1:0] sorted_key;
        logic             run_end;
        logic             overflowed;
    } t_sorted;

    localparam int HOLD_AT     = 30;
    localparam int HOLD_CYCLES = 400;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [KEY_W-1:0] s_axis_tdata = '0;   // [7:0] key
    logic             s_axis_tlast = 1'b0; // batch_end
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [KEY_W-1:0] m_axis_tdata;        // [7:0] sorted_key
    logic             m_axis_tlast;        // run_end
    logic             m_axis_tuser;        // [0] overflowed

    // Histogram shadow that mirrors the block's state.
    logic [CNT_W-1:0] hist [NUM_BINS];
    int unsigned      hist_top;
    int unsigned      hist_loaded;
    logic             hist_dropped;

    t_key_item pending_keys [$];
    t_sorted   sorted_due [$];
    int        keys_taken;
    int        total_keys;
    int        errors;
    int        hold_left;
    bit        hold_started;

    counting_sort_engine_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    // Counts one key and, on a closing key, drains the histogram into the
    // queue of sorted keys that the block owes.
    function automatic void count_key(input logic [KEY_W-1:0] key, input logic closing);
        int unsigned k;
        int unsigned bin;
        int          produced;
        t_sorted     res;
        k = key & (NUM_BINS - 1);
        if (hist_loaded < MAX_ITEMS) begin
            hist[k] = hist[k] + 1'b1;
            if (k > hist_top)
                hist_top = k;
            hist_loaded++;
        end else begin
            hist_dropped = 1'b1;
        end
        if (!closing)
            return;
        produced = 0;
        for (bin = 0; bin <= hist_top && bin < NUM_BINS; bin++) begin
            while (hist[bin] > 0 && produced < MAX_ITEMS) begin
                res.sorted_key = KEY_W'(bin);
                res.run_end    = 1'b0;
                res.overflowed = hist_dropped;
                sorted_due.push_back(res);
                produced++;
                hist[bin] = hist[bin] - 1'b1;
            end
            hist[bin] = '0;
        end
        if (produced > 0)
            sorted_due[sorted_due.size() - 1].run_end = 1'b1;
        hist_top     = 0;
        hist_loaded  = 0;
        hist_dropped = 1'b0;
    endfunction

    function automatic int idle_phase();
        if (total_keys == 0)
            return 0;
        return (keys_taken * 4) / total_keys;
    endfunction

    function automatic int sender_gap_pct();
        case (idle_phase())
            1: return 54;
            3: return 12;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct();
        case (idle_phase())
            2: return 54;
            3: return 12;
            default: return 0;
        endcase
    endfunction

    function automatic void add_batch(input int count, input int lo, input int hi);
        t_key_item item;
        for (int i = 0; i < count; i++) begin
            item.key       = KEY_W'($urandom_range(hi, lo));
            item.batch_end = (i == count - 1);
            pending_keys.push_back(item);
        end
    endfunction

    function automatic void add_key(input int key, input logic closing);
        t_key_item item;
        item.key       = KEY_W'(key);
        item.batch_end = closing;
        pending_keys.push_back(item);
    endfunction

    // Sender side.
    always @(posedge i_clk) begin
        t_key_item item;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                count_key(s_axis_tdata, s_axis_tlast);
                keys_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_keys.size() > 0 && $urandom_range(99) >= sender_gap_pct()) begin
                    item = pending_keys.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= item.key;
                    s_axis_tlast  <= item.batch_end;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // One long receiver hold-off while the sender keeps offering keys.
    always @(posedge i_clk) begin
        if (!hold_started && keys_taken >= HOLD_AT) begin
            hold_started <= 1'b1;
            hold_left    <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver side and result check.
    always @(posedge i_clk) begin
        t_sorted got;
        t_sorted want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.sorted_key = m_axis_tdata;
                got.run_end    = m_axis_tlast;
                got.overflowed = m_axis_tuser;
                if (sorted_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected sorted key %0d (last %0b, overflow %0b)",
                             $time, got.sorted_key, got.run_end, got.overflowed);
                end else begin
                    want = sorted_due.pop_front();
                    if (got.sorted_key !== want.sorted_key) begin
                        errors++;
                        $display("%0t: sorted_key expected %0d, got %0d",
                                 $time, want.sorted_key, got.sorted_key);
                    end
                    if (got.run_end !== want.run_end) begin
                        errors++;
                        $display("%0t: run_end expected %0b, got %0b",
                                 $time, want.run_end, got.run_end);
                    end
                    if (got.overflowed !== want.overflowed) begin
                        errors++;
                        $display("%0t: overflowed expected %0b, got %0b",
                                 $time, want.overflowed, got.overflowed);
                    end
                end
            end
            m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= receiver_stall_pct());
        end
    end

    initial begin
        for (int i = 0; i < NUM_BINS; i++)
            hist[i] = '0;
        hist_top     = 0;
        hist_loaded  = 0;
        hist_dropped = 1'b0;
        keys_taken   = 0;
        total_keys   = 0;
        errors       = 0;
        hold_left    = 0;
        hold_started = 1'b0;

        // Smallest and largest keys alone, then mixes with repeats.
        add_key(0, 1'b1);
        add_key(255, 1'b1);
        add_key(7, 1'b0);
        add_key(7, 1'b0);
        add_key(0, 1'b0);
        add_key(255, 1'b0);
        add_key(7, 1'b0);
        add_key(3, 1'b1);
        add_key(128, 1'b0);
        add_key(1, 1'b0);
        add_key(1, 1'b0);
        add_key(254, 1'b1);
        add_key(42, 1'b0);
        add_key(42, 1'b0);
        add_key(42, 1'b1);

        // A batch that exactly fills, one whose closing key is dropped, and
        // one that drops several keys.
        add_batch(64, 0, 255);
        add_batch(65, 0, 15);
        add_batch(70, 200, 255);

        while (pending_keys.size() < 410) begin
            int base;
            int count;
            if ($urandom_range(9) == 0)
                count = $urandom_range(72, 60);
            else
                count = $urandom_range(12, 1);
            if ($urandom_range(1) == 0) begin
                add_batch(count, 0, 255);
            end else begin
                base = $urandom_range(248);
                add_batch(count, base, base + 7);
            end
        end
        total_keys = pending_keys.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_keys.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
        while (sorted_due.size() != 0)
            @(posedge i_clk);
        // A full scan reads and checks every bin.
        repeat (2 * NUM_BINS + 64) @(posedge i_clk);

        if (sorted_due.size() != 0) begin
            errors++;
            $display("%0t: %0d sorted keys never arrived", $time, sorted_due.size());
        end
        if (errors == 0)
            $display("counting_sort_engine_unit verification clean");
        else
            $display("counting_sort_engine_unit verification failed");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("counting_sort_engine_unit verification failed");
        $finish;
    end

endmodule
